// File: rtl/core/pfoit_pkg.sv
// Package for the plane find-or-insert table: key and result structs,
// table sizing constants and the IEEE equality helper. No dependencies.
package pfoit_pkg;

  localparam int unsigned TableEntries = 8192;
  localparam int unsigned AddrW = $clog2(TableEntries);
  localparam int unsigned CountW = $clog2(TableEntries + 1);
  localparam int unsigned IndexW = 13;
  localparam int unsigned TypeW = 3;

  typedef struct packed {
    logic [31:0]      normal_x;
    logic [31:0]      normal_y;
    logic [31:0]      normal_z;
    logic [31:0]      distance;
    logic [TypeW-1:0] plane_type;
  } key_t;

  typedef struct packed {
    logic [IndexW-1:0] entry_index;
    logic              was_inserted;
    logic              table_full;
  } result_t;

  localparam logic [31:0] MagMask = 32'h7FFF_FFFF;
  localparam logic [31:0] ExpAllOnes = 32'h7F80_0000;

  // IEEE equality on single-precision bit patterns: NaN never equal, +0 == -0.
  function automatic logic float_eq(logic [31:0] a, logic [31:0] b);
    logic nan_a;
    logic nan_b;
    nan_a = (a & MagMask) > ExpAllOnes;
    nan_b = (b & MagMask) > ExpAllOnes;
    return !nan_a && !nan_b && ((a == b) || (((a | b) & MagMask) == 32'd0));
  endfunction

endpackage

// File: rtl/core/plane_find_or_insert_table_unit.sv
// Top level of the plane find-or-insert table: a scan sequencer over one
// synchronous key memory. Depends on pfoit_pkg.
//
//   Channel   Direction  Handshake          Payload
//   key       in         key_valid/ready    pfoit_pkg::key_t
//   result    out        res_valid/ready    pfoit_pkg::result_t
//
// A key's result is registered after the key is accepted, following these steps:
// one memory read per stored entry through the single read port, one compare
// stage, leaving the scan, and finishing in StDone (append write on a miss). A
// hit ends the scan early. The unit returns to idle before it takes the next
// key. Reset empties the table at once, with no sweep.
// The result sits in an output register; the next key is accepted while it
// waits, but its own result holds until the register is taken.
module plane_find_or_insert_table_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                key_valid_i,
  output logic                key_ready_o,
  input  pfoit_pkg::key_t     key_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output pfoit_pkg::result_t  res_o
);
  import pfoit_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AddrW-1:0]  cmp_ptr_q;
  logic              cmp_vld_q;
  logic              hit_q, hit_d;
  logic [AddrW-1:0]  hit_idx_q, hit_idx_d;
  key_t              key_q;
  logic              res_vld_q, res_vld_d;
  result_t           res_q, res_d;

  key_t              mem [TableEntries];
  key_t              rd_data_q;
  logic              mem_we;
  logic              rd_en;
  logic              match;

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AddrW-1:0]] <= key_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_ptr_q[AddrW-1:0]];
    end
  end

  assign key_ready_o = (state_q == StIdle);
  assign rd_en = (state_q == StScan) && !hit_q && (rd_ptr_q < count_q);

  // Compare the entry read last cycle against the held key.
  assign match = cmp_vld_q && !hit_q &&
                 (rd_data_q.plane_type == key_q.plane_type) &&
                 float_eq(rd_data_q.distance, key_q.distance) &&
                 float_eq(rd_data_q.normal_x, key_q.normal_x) &&
                 float_eq(rd_data_q.normal_y, key_q.normal_y) &&
                 float_eq(rd_data_q.normal_z, key_q.normal_z);

  // Sequencer: scan entries in order, then report and append on a miss unless the table is full.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rd_ptr_d  = rd_ptr_q;
    hit_d     = hit_q || match;
    hit_idx_d = match ? cmp_ptr_q : hit_idx_q;
    res_vld_d = res_vld_q && !res_ready_i;
    res_d     = res_q;
    mem_we    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (key_valid_i) begin
          state_d  = StScan;
          rd_ptr_d = '0;
          hit_d    = 1'b0;
        end
      end
      StScan: begin
        if (rd_en) begin
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        if (!rd_en && !cmp_vld_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!res_vld_d) begin
          res_vld_d = 1'b1;
          state_d   = StIdle;
          if (hit_q) begin
            res_d = '{entry_index: IndexW'(hit_idx_q), was_inserted: 1'b0,
                      table_full: 1'b0};
          end else if (count_q >= CountW'(TableEntries)) begin
            res_d = '{entry_index: '0, was_inserted: 1'b0, table_full: 1'b1};
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
            res_d   = '{entry_index: IndexW'(count_q), was_inserted: 1'b1,
                        table_full: 1'b0};
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      rd_ptr_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rd_ptr_q  <= rd_ptr_d;
      cmp_vld_q <= rd_en;
      hit_q     <= hit_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_ptr_q <= rd_ptr_q[AddrW-1:0];
    hit_idx_q <= hit_idx_d;
    res_q     <= res_d;
    if (key_valid_i && key_ready_o) begin
      key_q <= key_i;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
